// ----- sv/vrbp_pkg.sv -----
// Package for the variant record byte parser.
// Holds the character codes, field numbers and zygosity codes used by the core.
// No dependencies.
package vrbp_pkg;

    // Character codes recognised in the text stream.
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_O    = 8'h6F;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_DASH = 8'h2D;

    // Field numbers within one line.
    localparam logic [2:0] FLD_CHROM = 3'd0;
    localparam logic [2:0] FLD_POS   = 3'd1;
    localparam logic [2:0] FLD_ID    = 3'd2;
    localparam logic [2:0] FLD_REF   = 3'd3;
    localparam logic [2:0] FLD_ALT   = 3'd4;
    localparam logic [2:0] FLD_INFO  = 3'd7;

    // Zygosity codes.
    localparam logic [1:0] ZYG_HET = 2'd1;
    localparam logic [1:0] ZYG_HOM = 2'd2;

endpackage

// ----- sv/variant_record_byte_parser_core.sv -----
// Variant record byte parser core: input register, parser state and result register.
// Depends on vrbp_pkg for character codes, field numbers and zygosity codes.
//
// Usage:
//   Input channel: i_data_byte with i_in_valid / o_in_ready carries one text byte per word.
//   Output channel: o_chrom, o_position, o_ident, o_ref_allele, o_alt_allele and
//   o_zygosity with o_out_valid / i_out_ready carry one parsed record per word.
//   Throughput is one byte per cycle while no record is held back by a stalled
//   receiver. A byte accepted into the input register is parsed at the edge that
//   drains it, which also loads any record it causes into the output register, so the
//   record is offered from that edge on. Most bytes cause no record; the second byte
//   of the info field causes exactly one.
//   When the receiver stalls, a record waits in the output register while bytes that
//   cause no record keep flowing; only a byte that would cause a second record is held
//   in the input register, which then drops o_in_ready until the output is taken.
//   Reset (i_rst_n low at a clock edge) empties both registers, returns the parser to
//   the chromosome field with zeroed accumulators and sets both held alleles to '-'.
module variant_record_byte_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_chrom,
    output logic [31:0] o_position,
    output logic [63:0] o_ident,
    output logic [7:0]  o_ref_allele,
    output logic [7:0]  o_alt_allele,
    output logic [1:0]  o_zygosity
);

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Parser state.
    logic [2:0]  r_field, n_field;
    logic [1:0]  r_skip, n_skip;
    logic        r_id_chk, n_id_chk;
    logic        r_zyg_pend, n_zyg_pend;
    logic        r_ignore, n_ignore;
    logic [7:0]  r_acc_chrom, n_acc_chrom;
    logic [31:0] r_acc_pos, n_acc_pos;
    logic [63:0] r_acc_id, n_acc_id;
    logic [7:0]  r_held_ref, n_held_ref;
    logic [7:0]  r_held_alt, n_held_alt;

    // Result register.
    logic        r_out_valid;
    logic [7:0]  r_chrom;
    logic [31:0] r_position;
    logic [63:0] r_ident;
    logic [7:0]  r_ref;
    logic [7:0]  r_alt;
    logic [1:0]  r_zyg;

    logic       will_emit;
    logic       advance;
    logic       in_load;
    logic [7:0] b;

    assign b = r_in_byte;

    // A byte emits a record when it is the tested info byte and nothing earlier claims it.
    assign will_emit = !r_ignore && !r_id_chk && (r_skip == 2'd0) && r_zyg_pend;
    assign advance   = r_in_valid && (!will_emit || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_load    = i_in_valid && o_in_ready;

    // Next parser state from the held byte, following the rules in priority order.
    always_comb begin
        n_field     = r_field;
        n_skip      = r_skip;
        n_id_chk    = r_id_chk;
        n_zyg_pend  = r_zyg_pend;
        n_ignore    = r_ignore;
        n_acc_chrom = r_acc_chrom;
        n_acc_pos   = r_acc_pos;
        n_acc_id    = r_acc_id;
        n_held_ref  = r_held_ref;
        n_held_alt  = r_held_alt;
        if (r_ignore) begin
            if (b == vrbp_pkg::CH_NL) begin
                n_ignore = 1'b0;
            end
        end else if (r_id_chk) begin
            n_id_chk = 1'b0;
            if (b == vrbp_pkg::CH_DOT) begin
                n_field  = vrbp_pkg::FLD_REF;
                n_acc_id = 64'd0;
            end
            n_skip = 2'd1;
        end else if (r_skip != 2'd0) begin
            n_skip = r_skip - 2'd1;
        end else if (r_zyg_pend) begin
            n_zyg_pend  = 1'b0;
            n_acc_chrom = 8'd0;
            n_acc_pos   = 32'd0;
            n_acc_id    = 64'd0;
            n_held_ref  = vrbp_pkg::CH_DASH;
            n_held_alt  = vrbp_pkg::CH_DASH;
            n_field     = vrbp_pkg::FLD_CHROM;
            n_ignore    = (b != vrbp_pkg::CH_NL);
        end else if (b == vrbp_pkg::CH_HASH) begin
            n_ignore = 1'b1;
        end else if (b == vrbp_pkg::CH_TAB) begin
            // The field number saturates in the info field.
            if (r_field != vrbp_pkg::FLD_INFO) begin
                n_field = r_field + 3'd1;
            end
            if (r_field == vrbp_pkg::FLD_POS) begin
                n_id_chk = 1'b1;
            end
        end else begin
            // Decimal accumulation: acc * 10 + (byte - '0'), wrapping at the field width.
            case (r_field)
                vrbp_pkg::FLD_CHROM: begin
                    n_acc_chrom = (r_acc_chrom << 3) + (r_acc_chrom << 1) + b
                                - vrbp_pkg::CH_ZERO;
                end
                vrbp_pkg::FLD_POS: begin
                    n_acc_pos = (r_acc_pos << 3) + (r_acc_pos << 1) + {24'd0, b}
                              - {24'd0, vrbp_pkg::CH_ZERO};
                end
                vrbp_pkg::FLD_ID: begin
                    n_acc_id = (r_acc_id << 3) + (r_acc_id << 1) + {56'd0, b}
                             - {56'd0, vrbp_pkg::CH_ZERO};
                end
                vrbp_pkg::FLD_REF: begin
                    n_held_ref = b;
                end
                vrbp_pkg::FLD_ALT: begin
                    n_held_alt = b;
                end
                vrbp_pkg::FLD_INFO: begin
                    n_zyg_pend = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Input register: takes a word whenever the slot is free or being drained.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (in_load) begin
            r_in_byte <= i_data_byte;
        end
    end

    // Parser state update, once per parsed byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field     <= vrbp_pkg::FLD_CHROM;
            r_skip      <= 2'd0;
            r_id_chk    <= 1'b0;
            r_zyg_pend  <= 1'b0;
            r_ignore    <= 1'b0;
            r_acc_chrom <= 8'd0;
            r_acc_pos   <= 32'd0;
            r_acc_id    <= 64'd0;
            r_held_ref  <= vrbp_pkg::CH_DASH;
            r_held_alt  <= vrbp_pkg::CH_DASH;
        end else if (advance) begin
            r_field     <= n_field;
            r_skip      <= n_skip;
            r_id_chk    <= n_id_chk;
            r_zyg_pend  <= n_zyg_pend;
            r_ignore    <= n_ignore;
            r_acc_chrom <= n_acc_chrom;
            r_acc_pos   <= n_acc_pos;
            r_acc_id    <= n_acc_id;
            r_held_ref  <= n_held_ref;
            r_held_alt  <= n_held_alt;
        end
    end

    // Result register: loads the finished record and holds it until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && will_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && will_emit) begin
            r_chrom    <= r_acc_chrom;
            r_position <= r_acc_pos;
            r_ident    <= r_acc_id;
            r_ref      <= r_held_ref;
            r_alt      <= r_held_alt;
            r_zyg      <= (b == vrbp_pkg::CH_O) ? vrbp_pkg::ZYG_HOM : vrbp_pkg::ZYG_HET;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_chrom      = r_chrom;
    assign o_position   = r_position;
    assign o_ident      = r_ident;
    assign o_ref_allele = r_ref;
    assign o_alt_allele = r_alt;
    assign o_zygosity   = r_zyg;

    // A pending identifier test only arises right after the tab into the identifier field.
    a_id_chk_field : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_id_chk |-> (r_field == vrbp_pkg::FLD_ID) && (r_skip == 2'd0))
        else $error("identifier test pending outside the identifier field");

    // Ignoring the rest of a line and awaiting the info byte never coincide.
    a_ignore_zyg_excl : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_ignore && r_zyg_pend))
        else $error("ignore and zygosity test both pending");

    // An offered record always carries a legal zygosity code.
    a_zyg_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_zyg == vrbp_pkg::ZYG_HET) || (r_zyg == vrbp_pkg::ZYG_HOM))
        else $error("illegal zygosity code on output");

    // A record is never overwritten while the receiver stalls.
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !(advance && will_emit))
        else $error("record overwritten during stall");

endmodule
